### rtl/maw_pkg.sv
// Package for the moving average block: payload structs, controller states,
// command and status structs, and shared constants. No dependencies.
package maw_pkg;

    localparam int MAW_WINDOW_MAX_DEF = 64;
    localparam int SAMPLE_W           = 16;
    localparam int WLEN_W             = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                window_full;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic sum_update;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic full;
    } t_ctrl_status;

endpackage

### rtl/maw_ctrl.sv
// Controller of the moving average block: sequences accept, sum update,
// the bit-serial divide and the result load. Depends on maw_pkg.
module maw_ctrl
    import maw_pkg::*;
#(
    parameter int WINDOW_MAX = MAW_WINDOW_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_cmd,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         o_idle
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int SUM_W = SAMPLE_W + PTR_W;
    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state = (i_in_cmd == CMD_CLEAR) ? ST_OUT : ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.sum_update = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

    // divide always runs its full bit count before the result
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_LAST) |=> (r_state == ST_OUT))
        else $error("divide did not end in result load");

    // clear goes straight to result load
    a_clear_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.item_load && i_in_cmd == CMD_CLEAR) |=> (r_state == ST_OUT))
        else $error("clear did not go to result load");

    // a result is loaded only into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a pending beat");

endmodule

### rtl/maw_dp.sv
// Datapath of the moving average block: length register, sample ring memory,
// running sum, fill state, bit-serial divider and output register.
// Depends on maw_pkg.
module maw_dp
    import maw_pkg::*;
#(
    parameter int WINDOW_MAX = MAW_WINDOW_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  t_in_item          i_in_data,
    input  logic              i_cfg_we,
    input  logic [WLEN_W-1:0] i_cfg_data,
    input  logic              i_out_stall,
    output t_ctrl_status      o_status,
    output logic              o_out_valid,
    output t_out_item         o_out_data
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int SUM_W = SAMPLE_W + PTR_W;

    // control state
    logic [WLEN_W-1:0] r_wlen;
    logic [SUM_W-1:0]  r_sum;
    logic [LEN_W-1:0]  r_count;
    logic [PTR_W-1:0]  r_pos;
    logic              r_full;
    logic              r_out_valid;

    // payload
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [SUM_W-1:0]    r_quo;
    logic [LEN_W-1:0]    r_rem;
    logic [LEN_W-1:0]    r_dvs;
    t_out_item           r_out_data;
    logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

    logic [LEN_W-1:0] eff_len;
    logic [PTR_W-1:0] pos_eff;
    logic [LEN_W-1:0] pos_inc;
    logic [PTR_W-1:0] pos_next;
    logic [LEN_W-1:0] count_inc;
    logic [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0] sum_roll;
    logic [LEN_W:0]   rem_sh;
    logic [LEN_W:0]   rem_sub;
    logic             rem_ge;
    logic             is_clear;

    // length clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(r_wlen) > WINDOW_MAX) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = LEN_W'(r_wlen);
        end
    end

    // ring pointer with wrap
    assign pos_eff   = (LEN_W'(r_pos) >= eff_len) ? '0 : r_pos;
    assign pos_inc   = LEN_W'(pos_eff) + LEN_W'(1);
    assign pos_next  = (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
    assign count_inc = r_count + LEN_W'(1);

    // running sum updates
    assign sum_add  = r_sum + SUM_W'(r_sample);
    assign sum_roll = r_sum - SUM_W'(r_old) + SUM_W'(r_sample);

    // one restoring divide step
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign rem_ge  = (rem_sh >= {1'b0, r_dvs});

    assign is_clear = (i_in_data.command == CMD_CLEAR);

    // sample memory, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_update) begin
            mem[pos_eff] <= r_sample;
        end
        r_old <= mem[pos_eff];
    end

    // window state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= WLEN_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wlen  <= i_cfg_data;
                r_sum   <= '0;
                r_count <= '0;
                r_pos   <= '0;
                r_full  <= 1'b0;
            end else if (i_cmd.item_load && is_clear) begin
                r_sum   <= '0;
                r_count <= '0;
                r_pos   <= '0;
                r_full  <= 1'b0;
            end else if (i_cmd.sum_update) begin
                r_pos <= pos_next;
                if (!r_full) begin
                    r_sum   <= sum_add;
                    r_count <= count_inc;
                    r_full  <= (count_inc >= eff_len);
                end else begin
                    r_sum <= sum_roll;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample capture, divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_sample <= i_in_data.sample;
            if (is_clear) begin
                r_quo <= '0;
            end
        end
        if (i_cmd.sum_update) begin
            r_quo <= r_full ? sum_roll : sum_add;
            r_rem <= '0;
            r_dvs <= r_full ? eff_len : count_inc;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
        if (i_cmd.out_load) begin
            r_out_data.average     <= r_quo[SAMPLE_W-1:0];
            r_out_data.window_full <= r_full;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.full     = r_full;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

### rtl/moving_average_with_fill_core.sv
// Top level of the moving average block: joins controller and datapath.
// Depends on maw_pkg, maw_ctrl and maw_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one beat carries a
//   command and a 16-bit sample. A sample beat adds to the window; a clear
//   beat empties it. Every input beat gives exactly one output beat.
//   Output channel (o_out_valid / i_out_stall / o_out_data): the truncated
//   mean of the window and the window-full flag; zero after a clear.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
//   window length (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX); each
//   write also empties the window. Ready is high while the block is idle.
// Timing:
//   A sample beat passes through the sum update, the bit-serial divide over
//   SUM_W quotient bits (SUM_W = 16 + log2 WINDOW_MAX) at one bit per cycle,
//   and the result load. A clear beat goes straight to the result load. One beat is
//   in work at a time; o_in_stall is high while it is.
// Reset: synchronous, active low; length returns to 8, window empty.
// Stall: a finished result waits in the output register; the next beat is
//   accepted meanwhile, and its result waits until the register drains.
module moving_average_with_fill_core
    import maw_pkg::*;
#(
    parameter int WINDOW_MAX = MAW_WINDOW_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WLEN_W-1:0] i_cfg_data
);

    t_ctrl_cmd    w_cmd;
    t_ctrl_status w_status;
    logic         w_idle;
    logic         w_cfg_we;

    assign o_in_stall  = !w_idle;
    assign o_cfg_ready = w_idle;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    maw_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.command),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    maw_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted beat keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new output beat only comes from work in progress
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output beat without an accepted input");

    // a length write empties the window
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_we |=> !w_status.full)
        else $error("window still full after length write");

endmodule
